@@ src/adaptive_unsharp_mask_blend_defines.svh @@
// Assertion macros shared by the sharpening pipeline.
`ifndef ADAPTIVE_UNSHARP_MASK_BLEND_DEFINES_SVH
`define ADAPTIVE_UNSHARP_MASK_BLEND_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AUM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aum assertion failed");

// Next-cycle implication, checked outside reset.
`define AUM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aum assertion failed");

`endif

@@ src/aum_pkg.sv @@
`timescale 1ns / 1ps

package aum_pkg;

    localparam int CFG_INDEX_BITS   = 4;
    localparam int CFG_DATA_BITS    = 32;
    localparam int AMOUNT_BITS      = 24;
    localparam int AMOUNT_FRAC_BITS = 16;
    localparam int COEF_BITS        = 32;
    // Register stages from brightness to the selected amount.
    localparam int AMOUNT_LATENCY   = 5;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_AMOUNT_MIN       = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AMOUNT_MAX       = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_THRESHOLD  = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRANSITION_HALF  = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CURVE_A          = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CURVE_B          = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CURVE_C          = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CURVE_D          = 4'd7;

    localparam logic signed [AMOUNT_BITS-1:0] AMOUNT_MAX = 24'sh7FFFFF;
    localparam logic signed [AMOUNT_BITS-1:0] AMOUNT_MIN = -24'sh800000;

    localparam logic [CFG_DATA_BITS-1:0] LEVEL_THRESHOLD_RESET = 32'h0000_8000;

    typedef struct packed {
        logic signed [AMOUNT_BITS-1:0] amount_min;
        logic signed [AMOUNT_BITS-1:0] amount_max;
        logic signed [COEF_BITS-1:0]   curve_a;
        logic signed [COEF_BITS-1:0]   curve_b;
        logic signed [COEF_BITS-1:0]   curve_c;
        logic signed [COEF_BITS-1:0]   curve_d;
    } curve_cfg_t;

    // 1.0 for both amounts and the constant term, zero elsewhere.
    localparam curve_cfg_t CURVE_RESET = '{
        amount_min: 24'sh010000,
        amount_max: 24'sh010000,
        curve_a:    32'sh0,
        curve_b:    32'sh0,
        curve_c:    32'sh0,
        curve_d:    32'sh0001_0000
    };

endpackage

@@ src/aum_cfg.sv @@
`timescale 1ns / 1ps

module aum_cfg #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [aum_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [aum_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output aum_pkg::curve_cfg_t                curve,
    output logic [PIXEL_BITS-1:0]              level_threshold,
    output logic [PIXEL_BITS-1:0]              transition_half_width
);
    import aum_pkg::*;

    curve_cfg_t            curve_reg;
    curve_cfg_t            curve_next;
    logic [PIXEL_BITS-1:0] threshold_reg;
    logic [PIXEL_BITS-1:0] threshold_next;
    logic [PIXEL_BITS-1:0] half_width_reg;
    logic [PIXEL_BITS-1:0] half_width_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        curve_next      = curve_reg;
        threshold_next  = threshold_reg;
        half_width_next = half_width_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_AMOUNT_MIN:      curve_next.amount_min = cfg_data[AMOUNT_BITS-1:0];
                CFG_AMOUNT_MAX:      curve_next.amount_max = cfg_data[AMOUNT_BITS-1:0];
                CFG_LEVEL_THRESHOLD: threshold_next        = cfg_data[PIXEL_BITS-1:0];
                CFG_TRANSITION_HALF: half_width_next       = cfg_data[PIXEL_BITS-1:0];
                CFG_CURVE_A:         curve_next.curve_a    = cfg_data[COEF_BITS-1:0];
                CFG_CURVE_B:         curve_next.curve_b    = cfg_data[COEF_BITS-1:0];
                CFG_CURVE_C:         curve_next.curve_c    = cfg_data[COEF_BITS-1:0];
                CFG_CURVE_D:         curve_next.curve_d    = cfg_data[COEF_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_reg      <= CURVE_RESET;
            threshold_reg  <= LEVEL_THRESHOLD_RESET[PIXEL_BITS-1:0];
            half_width_reg <= '0;
        end
        else
        begin
            curve_reg      <= curve_next;
            threshold_reg  <= threshold_next;
            half_width_reg <= half_width_next;
        end
    end

    assign curve                 = curve_reg;
    assign level_threshold       = threshold_reg;
    assign transition_half_width = half_width_reg;

endmodule

@@ src/aum_amount.sv @@
`timescale 1ns / 1ps

module aum_amount #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [PIXEL_BITS-1:0]                  brightness,
    input  logic [PIXEL_BITS-1:0]                  level_threshold,
    input  logic [PIXEL_BITS-1:0]                  transition_half_width,
    input  aum_pkg::curve_cfg_t                    curve,
    output logic                                   amount_valid,
    output logic signed [aum_pkg::AMOUNT_BITS-1:0] amount
);
    import aum_pkg::*;

    // Each Horner step grows the accumulator by one bit: the product shifted
    // back by PIXEL_BITS never exceeds the accumulator in magnitude.
    localparam int ACC1_BITS  = COEF_BITS + 1;
    localparam int ACC2_BITS  = COEF_BITS + 2;
    localparam int ACC3_BITS  = COEF_BITS + 3;
    localparam int PROD1_BITS = COEF_BITS + PIXEL_BITS + 1;
    localparam int PROD2_BITS = ACC1_BITS + PIXEL_BITS + 1;
    localparam int PROD3_BITS = ACC2_BITS + PIXEL_BITS + 1;
    localparam int FLAG_BITS  = AMOUNT_LATENCY - 1;

    logic signed [PIXEL_BITS+1:0] band_lo;
    logic [PIXEL_BITS:0]          band_hi;
    logic                         below_in;
    logic                         above_in;

    logic [AMOUNT_LATENCY-1:0] valid_reg;
    logic [AMOUNT_LATENCY-1:0] valid_next;
    logic [FLAG_BITS-1:0]      below_reg;
    logic [FLAG_BITS-1:0]      below_next;
    logic [FLAG_BITS-1:0]      above_reg;
    logic [FLAG_BITS-1:0]      above_next;

    logic [PIXEL_BITS-1:0] lum1_reg;
    logic [PIXEL_BITS-1:0] lum1_next;
    logic [PIXEL_BITS-1:0] lum2_reg;
    logic [PIXEL_BITS-1:0] lum2_next;
    logic [PIXEL_BITS-1:0] lum3_reg;
    logic [PIXEL_BITS-1:0] lum3_next;

    logic signed [PROD1_BITS-1:0] prod1_reg;
    logic signed [PROD1_BITS-1:0] prod1_next;
    logic signed [PROD2_BITS-1:0] prod2_reg;
    logic signed [PROD2_BITS-1:0] prod2_next;
    logic signed [PROD3_BITS-1:0] prod3_reg;
    logic signed [PROD3_BITS-1:0] prod3_next;

    logic signed [ACC1_BITS-1:0]   acc1;
    logic signed [ACC2_BITS-1:0]   acc2;
    logic signed [ACC3_BITS-1:0]   acc3;
    logic signed [AMOUNT_BITS-1:0] amount_sat;
    logic signed [AMOUNT_BITS-1:0] amount_reg;
    logic signed [AMOUNT_BITS-1:0] amount_next;

    // The upper band end is one bit wider than the pixel, the lower end two bits
    // wider and signed, so that they neither wrap below zero nor past full scale.
    assign band_lo  = $signed({2'b00, level_threshold}) - $signed({2'b00, transition_half_width});
    assign band_hi  = {1'b0, level_threshold} + {1'b0, transition_half_width};
    assign below_in = $signed({2'b00, brightness}) < band_lo;
    assign above_in = {1'b0, brightness} > band_hi;

    assign valid_next = {valid_reg[AMOUNT_LATENCY-2:0], in_valid};
    assign below_next = {below_reg[FLAG_BITS-2:0], below_in};
    assign above_next = {above_reg[FLAG_BITS-2:0], above_in};

    assign lum1_next = brightness;
    assign lum2_next = lum1_reg;
    assign lum3_next = lum2_reg;

    // Horner's rule, one multiply per stage; the arithmetic shift floors.
    assign prod1_next = PROD1_BITS'(curve.curve_a)
                        * PROD1_BITS'($signed({1'b0, lum1_reg}));
    assign acc1       = $signed(prod1_reg[PROD1_BITS-1:PIXEL_BITS])
                        + ACC1_BITS'(curve.curve_b);
    assign prod2_next = PROD2_BITS'(acc1) * PROD2_BITS'($signed({1'b0, lum2_reg}));
    assign acc2       = $signed(prod2_reg[PROD2_BITS-1:PIXEL_BITS])
                        + ACC2_BITS'(curve.curve_c);
    assign prod3_next = PROD3_BITS'(acc2) * PROD3_BITS'($signed({1'b0, lum3_reg}));
    assign acc3       = $signed(prod3_reg[PROD3_BITS-1:PIXEL_BITS])
                        + ACC3_BITS'(curve.curve_d);

    always_comb
    begin
        if (acc3 > ACC3_BITS'(AMOUNT_MAX))
        begin
            amount_sat = AMOUNT_MAX;
        end
        else if (acc3 < ACC3_BITS'(AMOUNT_MIN))
        begin
            amount_sat = AMOUNT_MIN;
        end
        else
        begin
            amount_sat = acc3[AMOUNT_BITS-1:0];
        end

        if (below_reg[FLAG_BITS-1])
        begin
            amount_next = curve.amount_min;
        end
        else if (above_reg[FLAG_BITS-1])
        begin
            amount_next = curve.amount_max;
        end
        else
        begin
            amount_next = amount_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            below_reg  <= below_next;
            above_reg  <= above_next;
            lum1_reg   <= lum1_next;
            lum2_reg   <= lum2_next;
            lum3_reg   <= lum3_next;
            prod1_reg  <= prod1_next;
            prod2_reg  <= prod2_next;
            prod3_reg  <= prod3_next;
            amount_reg <= amount_next;
        end
    end

    assign amount_valid = valid_reg[AMOUNT_LATENCY-1];
    assign amount       = amount_reg;

endmodule

@@ src/aum_blend.sv @@
`timescale 1ns / 1ps

module aum_blend #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [aum_pkg::AMOUNT_BITS-1:0] amount,
    input  logic [PIXEL_BITS-1:0]                  blurred_pixel,
    input  logic signed [PIXEL_BITS:0]             pixel_diff,
    output logic                                   out_valid,
    output logic [PIXEL_BITS-1:0]                  sharpened_pixel,
    output logic                                   was_clamped
);
    import aum_pkg::*;

    localparam int PROD_BITS  = AMOUNT_BITS + PIXEL_BITS + 1;
    localparam int SHIFT_BITS = PROD_BITS - AMOUNT_FRAC_BITS;
    localparam int SUM_BITS   = SHIFT_BITS + 1;

    logic                         mid_valid_reg;
    logic                         mid_valid_next;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [PROD_BITS-1:0]  prod_next;
    logic [PIXEL_BITS-1:0]        blr_reg;
    logic [PIXEL_BITS-1:0]        blr_next;

    logic signed [SUM_BITS-1:0]   sum;
    logic [PIXEL_BITS-1:0]        pixel_next;
    logic                         clamp_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic [PIXEL_BITS-1:0]        pixel_reg;
    logic                         clamp_reg;

    assign mid_valid_next = in_valid;
    assign valid_next     = mid_valid_reg;
    assign prod_next      = PROD_BITS'(amount) * PROD_BITS'(pixel_diff);
    assign blr_next       = blurred_pixel;

    assign sum = SUM_BITS'($signed(prod_reg[PROD_BITS-1:AMOUNT_FRAC_BITS]))
                 + $signed({{(SUM_BITS-PIXEL_BITS){1'b0}}, blr_reg});

    always_comb
    begin
        if (sum[SUM_BITS-1])
        begin
            pixel_next = '0;
            clamp_next = 1'b1;
        end
        else if (|sum[SUM_BITS-2:PIXEL_BITS])
        begin
            pixel_next = '1;
            clamp_next = 1'b1;
        end
        else
        begin
            pixel_next = sum[PIXEL_BITS-1:0];
            clamp_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            mid_valid_reg <= mid_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            blr_reg   <= blr_next;
            pixel_reg <= pixel_next;
            clamp_reg <= clamp_next;
        end
    end

    assign out_valid       = valid_reg;
    assign sharpened_pixel = pixel_reg;
    assign was_clamped     = clamp_reg;

endmodule

@@ src/adaptive_unsharp_mask_blend.sv @@
// Channel   Direction  Handshake                Payload
// input     in         in_valid / in_ready      source_pixel, blurred_pixel, brightness
// output    out        out_valid / out_ready    sharpened_pixel, was_clamped
// config    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One pixel enters per cycle unless stalled; the amount stages feed the blend stages.
// The three Horner multiplies and the blend multiply each own a pipeline stage.
// When the output register holds a transaction that is not taken, every stage freezes.
// Reset clears all valid bits and loads the register defaults; cfg_ready is always high.
`timescale 1ns / 1ps
`include "adaptive_unsharp_mask_blend_defines.svh"

module adaptive_unsharp_mask_blend #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [aum_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [aum_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [PIXEL_BITS-1:0]              source_pixel,
    input  logic [PIXEL_BITS-1:0]              blurred_pixel,
    input  logic [PIXEL_BITS-1:0]              brightness,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [PIXEL_BITS-1:0]              sharpened_pixel,
    output logic                               was_clamped
);
    import aum_pkg::*;

    curve_cfg_t                    curve;
    logic [PIXEL_BITS-1:0]         level_threshold;
    logic [PIXEL_BITS-1:0]         transition_half_width;
    logic                          en;
    logic                          amount_valid;
    logic signed [AMOUNT_BITS-1:0] amount;

    // Pixel side data travels beside the amount pipeline.
    logic signed [PIXEL_BITS:0]    diff_pipe_reg [AMOUNT_LATENCY];
    logic signed [PIXEL_BITS:0]    diff_pipe_next;
    logic [PIXEL_BITS-1:0]         blr_pipe_reg  [AMOUNT_LATENCY];
    logic [PIXEL_BITS-1:0]         blr_pipe_next;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign diff_pipe_next = $signed({1'b0, source_pixel}) - $signed({1'b0, blurred_pixel});
    assign blr_pipe_next  = blurred_pixel;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_pipe_reg[0] <= diff_pipe_next;
            blr_pipe_reg[0]  <= blr_pipe_next;
            for (int i = 1; i < AMOUNT_LATENCY; i++)
            begin
                diff_pipe_reg[i] <= diff_pipe_reg[i-1];
                blr_pipe_reg[i]  <= blr_pipe_reg[i-1];
            end
        end
    end

    aum_cfg #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_cfg (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .curve                 (curve),
        .level_threshold       (level_threshold),
        .transition_half_width (transition_half_width)
    );

    aum_amount #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_amount (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .en                    (en),
        .in_valid              (in_valid),
        .brightness            (brightness),
        .level_threshold       (level_threshold),
        .transition_half_width (transition_half_width),
        .curve                 (curve),
        .amount_valid          (amount_valid),
        .amount                (amount)
    );

    aum_blend #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_blend (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (amount_valid),
        .amount          (amount),
        .blurred_pixel   (blr_pipe_reg[AMOUNT_LATENCY-1]),
        .pixel_diff      (diff_pipe_reg[AMOUNT_LATENCY-1]),
        .out_valid       (out_valid),
        .sharpened_pixel (sharpened_pixel),
        .was_clamped     (was_clamped)
    );

    // A clamped result always sits at one end of the pixel range.
    `AUM_ASSERT_IMP(a_clamp_at_rail, clk, rst_n, out_valid && was_clamped, (sharpened_pixel == '0) || (sharpened_pixel == '1))
    // A stalled amount stage keeps its transaction and its value.
    `AUM_ASSERT_NXT(a_amount_hold, clk, rst_n, amount_valid && !en, amount_valid && $stable(amount))
    // A write to the constant term lands in the curve set in the next cycle.
    `AUM_ASSERT_NXT(a_cfg_curve_d, clk, rst_n, cfg_valid && cfg_ready && (cfg_index == CFG_CURVE_D), curve.curve_d == $past(cfg_data))

endmodule

@@ sim/aum_blend_checker.sv @@
`timescale 1ns / 1ps

module aum_blend_checker #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [aum_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [aum_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [PIXEL_BITS-1:0]              source_pixel,
    input  logic [PIXEL_BITS-1:0]              blurred_pixel,
    input  logic [PIXEL_BITS-1:0]              brightness,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [PIXEL_BITS-1:0]              sharpened_pixel,
    input  logic                               was_clamped,
    output int                                 mismatches,
    output int                                 outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  clamped;
    } pixel_result_t;

    pixel_result_t expected_pixels[$];

    // Shadow copy of the register file.
    logic signed [aum_pkg::AMOUNT_BITS-1:0] amount_lo;
    logic signed [aum_pkg::AMOUNT_BITS-1:0] amount_hi;
    logic        [PIXEL_BITS-1:0]           threshold;
    logic        [PIXEL_BITS-1:0]           half_width;
    logic signed [aum_pkg::COEF_BITS-1:0]   coef_a;
    logic signed [aum_pkg::COEF_BITS-1:0]   coef_b;
    logic signed [aum_pkg::COEF_BITS-1:0]   coef_c;
    logic signed [aum_pkg::COEF_BITS-1:0]   coef_d;

    function automatic pixel_result_t predict_sharpened(
        input logic [PIXEL_BITS-1:0] src,
        input logic [PIXEL_BITS-1:0] blr,
        input logic [PIXEL_BITS-1:0] lum
    );
        longint level;
        longint centre;
        longint span;
        longint amount;
        longint acc;
        longint src_l;
        longint blr_l;
        longint sum;
        longint pix_max;
        pixel_result_t res;
        level = longint'(lum);
        centre = longint'(threshold);
        span = longint'(half_width);
        if (level < centre - span) begin
            amount = longint'(amount_lo);
        end
        else if (level > centre + span) begin
            amount = longint'(amount_hi);
        end
        else begin
            // Arithmetic shifts of signed values round toward minus infinity.
            acc = longint'(coef_a);
            acc = ((acc * level) >>> PIXEL_BITS) + longint'(coef_b);
            acc = ((acc * level) >>> PIXEL_BITS) + longint'(coef_c);
            acc = ((acc * level) >>> PIXEL_BITS) + longint'(coef_d);
            if (acc > longint'(aum_pkg::AMOUNT_MAX))
                acc = longint'(aum_pkg::AMOUNT_MAX);
            if (acc < longint'(aum_pkg::AMOUNT_MIN))
                acc = longint'(aum_pkg::AMOUNT_MIN);
            amount = acc;
        end
        src_l = longint'(src);
        blr_l = longint'(blr);
        sum = blr_l + ((amount * (src_l - blr_l)) >>> aum_pkg::AMOUNT_FRAC_BITS);
        pix_max = (longint'(1) << PIXEL_BITS) - 1;
        if (sum < 0) begin
            res.pixel = '0;
            res.clamped = 1'b1;
        end
        else if (sum > pix_max) begin
            res.pixel = '1;
            res.clamped = 1'b1;
        end
        else begin
            res.pixel = sum[PIXEL_BITS-1:0];
            res.clamped = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        if (!rst_n) begin
            amount_lo = aum_pkg::CURVE_RESET.amount_min;
            amount_hi = aum_pkg::CURVE_RESET.amount_max;
            threshold = aum_pkg::LEVEL_THRESHOLD_RESET[PIXEL_BITS-1:0];
            half_width = '0;
            coef_a = aum_pkg::CURVE_RESET.curve_a;
            coef_b = aum_pkg::CURVE_RESET.curve_b;
            coef_c = aum_pkg::CURVE_RESET.curve_c;
            coef_d = aum_pkg::CURVE_RESET.curve_d;
            expected_pixels.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    aum_pkg::CFG_AMOUNT_MIN:      amount_lo = cfg_data[aum_pkg::AMOUNT_BITS-1:0];
                    aum_pkg::CFG_AMOUNT_MAX:      amount_hi = cfg_data[aum_pkg::AMOUNT_BITS-1:0];
                    aum_pkg::CFG_LEVEL_THRESHOLD: threshold = cfg_data[PIXEL_BITS-1:0];
                    aum_pkg::CFG_TRANSITION_HALF: half_width = cfg_data[PIXEL_BITS-1:0];
                    aum_pkg::CFG_CURVE_A:         coef_a = cfg_data;
                    aum_pkg::CFG_CURVE_B:         coef_b = cfg_data;
                    aum_pkg::CFG_CURVE_C:         coef_c = cfg_data;
                    aum_pkg::CFG_CURVE_D:         coef_d = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(
                    predict_sharpened(source_pixel, blurred_pixel, brightness));
            if (out_valid && out_ready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected output transaction %h/%b",
                                 $realtime, sharpened_pixel, was_clamped);
                end
                else begin
                    want = expected_pixels.pop_front();
                    if (want.pixel !== sharpened_pixel || want.clamped !== was_clamped) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: sharpened_pixel exp %h got %h, was_clamped exp %b got %b",
                                     $realtime, want.pixel, sharpened_pixel,
                                     want.clamped, was_clamped);
                    end
                end
            end
            outstanding = expected_pixels.size();
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int PIXEL_BITS       = 16;
    localparam int CLK_HALF         = 6;
    localparam int LIMIT_CYCLES     = 400000;
    localparam int RANDOM_PHASES    = 8;
    localparam int PIXELS_PER_PHASE = 250;
    localparam int PRESSURE_PHASE   = 1;
    localparam int HOLD_OFF_CYCLES  = 60;
    localparam int DRAIN_CYCLES     = 20;
    localparam int MAX_IDLE         = 4;
    localparam int AMOUNT_ONE       = 1 << aum_pkg::AMOUNT_FRAC_BITS;
    localparam int INDEX_COUNT      = 1 << aum_pkg::CFG_INDEX_BITS;

    localparam logic [PIXEL_BITS-1:0] PIX_FULL = '1;
    localparam logic [PIXEL_BITS-1:0] PIX_HALF = {1'b1, {(PIXEL_BITS-1){1'b0}}};
    localparam logic [31:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] COEF_MIN = 32'h8000_0000;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [aum_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [aum_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                               in_valid;
    logic                               in_ready;
    logic [PIXEL_BITS-1:0]              source_pixel;
    logic [PIXEL_BITS-1:0]              blurred_pixel;
    logic [PIXEL_BITS-1:0]              brightness;
    logic                               out_valid;
    logic                               out_ready;
    logic [PIXEL_BITS-1:0]              sharpened_pixel;
    logic                               was_clamped;

    int mismatches;
    int outstanding;
    int cycles;

    // Idle controls for the sender and the receiver.
    bit sender_quiet;
    bit receiver_quiet;
    int hold_request;

    // What the stimulus last wrote, used to aim brightness at the band.
    logic [PIXEL_BITS-1:0] cur_threshold;
    logic [PIXEL_BITS-1:0] cur_half;

    adaptive_unsharp_mask_blend #(
        .PIXEL_BITS(PIXEL_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .source_pixel    (source_pixel),
        .blurred_pixel   (blurred_pixel),
        .brightness      (brightness),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sharpened_pixel (sharpened_pixel),
        .was_clamped     (was_clamped)
    );

    aum_blend_checker #(
        .PIXEL_BITS(PIXEL_BITS)
    ) blend_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .source_pixel    (source_pixel),
        .blurred_pixel   (blurred_pixel),
        .brightness      (brightness),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sharpened_pixel (sharpened_pixel),
        .was_clamped     (was_clamped),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles <= LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // Receiver: a random stall before each transaction, plus long hold-offs on request.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                out_ready = 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end
            stall = receiver_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic write_reg(input logic [aum_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [aum_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [31:0] amt_min, input logic [31:0] amt_max,
                             input logic [31:0] thr, input logic [31:0] half,
                             input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d);
        write_reg(aum_pkg::CFG_AMOUNT_MIN, amt_min);
        write_reg(aum_pkg::CFG_AMOUNT_MAX, amt_max);
        write_reg(aum_pkg::CFG_LEVEL_THRESHOLD, thr);
        write_reg(aum_pkg::CFG_TRANSITION_HALF, half);
        write_reg(aum_pkg::CFG_CURVE_A, a);
        write_reg(aum_pkg::CFG_CURVE_B, b);
        write_reg(aum_pkg::CFG_CURVE_C, c);
        write_reg(aum_pkg::CFG_CURVE_D, d);
        cur_threshold = thr[PIXEL_BITS-1:0];
        cur_half = half[PIXEL_BITS-1:0];
    endtask

    // Returns after the rising edge that accepted the transaction; valid stays up
    // so that a following item with no gap goes out back to back.
    task automatic push_pixel(input logic [PIXEL_BITS-1:0] src,
                              input logic [PIXEL_BITS-1:0] blr,
                              input logic [PIXEL_BITS-1:0] lum);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        source_pixel = src;
        blurred_pixel = blr;
        brightness = lum;
        do @(posedge clk); while (!in_ready);
    endtask

    // The block is idle once every accepted pixel has come back.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    function automatic logic [PIXEL_BITS-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return PIX_FULL;
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    // Half the time the brightness lands in or just around the transition band.
    function automatic logic [PIXEL_BITS-1:0] pick_level();
        int span;
        int lvl;
        if ($urandom_range(0, 1))
            return PIXEL_BITS'($urandom);
        span = int'(cur_half) + 2;
        lvl = int'(cur_threshold) + int'($urandom_range(0, 2 * span)) - span;
        if (lvl < 0)
            lvl = 0;
        if (lvl > int'(PIX_FULL))
            lvl = int'(PIX_FULL);
        return lvl[PIXEL_BITS-1:0];
    endfunction

    function automatic logic [31:0] pick_amount();
        case ($urandom_range(0, 5))
            0: return 32'(aum_pkg::AMOUNT_MAX);
            1: return 32'(aum_pkg::AMOUNT_MIN);
            2: return $urandom_range(0, 8 * AMOUNT_ONE) - 4 * AMOUNT_ONE;
            3: return $urandom;
            default: return AMOUNT_ONE;
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 6))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3: return $urandom;
            default: return $urandom_range(0, 8 * AMOUNT_ONE) - 4 * AMOUNT_ONE;
        endcase
    endfunction

    function automatic logic [31:0] pick_half();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return $urandom;
            default: return $urandom_range(0, 16'h2000);
        endcase
    endfunction

    task automatic random_setup();
        logic [31:0] amt;
        if ($urandom_range(0, 4) == 0) begin
            // Fixed amount across the whole brightness range.
            amt = pick_amount();
            configure(amt, amt, $urandom, pick_half(), '0, '0, '0,
                      {{8{amt[23]}}, amt[23:0]});
        end
        else begin
            configure(pick_amount(), pick_amount(), $urandom, pick_half(),
                      pick_coef(), pick_coef(), pick_coef(), pick_coef());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        source_pixel = '0;
        blurred_pixel = '0;
        brightness = '0;
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
        hold_request = 0;
        cur_threshold = PIX_HALF;
        cur_half = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Defaults after reset: amount of one everywhere.
        push_pixel('0, '0, '0);
        push_pixel(PIX_FULL, PIX_FULL, PIX_FULL);
        push_pixel(PIX_FULL, '0, PIX_HALF);
        push_pixel('0, PIX_FULL, PIX_HALF - 1'b1);
        drain();

        // Indexes past the last register must leave the settings alone.
        for (int idx = aum_pkg::CFG_CURVE_D + 1; idx < INDEX_COUNT; idx++)
            write_reg(idx[aum_pkg::CFG_INDEX_BITS-1:0], '1);
        push_pixel(PIX_FULL, '0, PIX_HALF + 1'b1);
        push_pixel(16'h1234, 16'h5678, PIX_HALF);
        drain();

        // Band 0x7000..0x9000, negative amount below, largest amount above.
        configure(32'h00FE_0000, 32'(aum_pkg::AMOUNT_MAX), 32'(PIX_HALF), 32'h1000,
                  '0, '0, 32'h0002_0000, 32'h0000_8000);
        push_pixel(PIX_FULL, '0, 16'h6FFF);
        push_pixel('0, PIX_FULL, 16'h6FFF);
        push_pixel(16'hC000, 16'h4000, 16'h7000);
        push_pixel(16'h4000, 16'hC000, 16'h9000);
        push_pixel(16'h4001, 16'h4000, 16'h9001);
        push_pixel(16'h4000, 16'h4001, 16'h9001);
        drain();

        // Band lower end below zero; the cubic saturates high.
        configure(AMOUNT_ONE, AMOUNT_ONE, '0, 32'(PIX_FULL),
                  COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        push_pixel(PIX_FULL, PIX_FULL, '0);
        push_pixel(PIX_HALF, PIX_HALF - 1'b1, PIX_FULL);
        drain();

        // Band upper end past the pixel range; the cubic saturates low.
        configure(AMOUNT_ONE, AMOUNT_ONE, 32'(PIX_FULL), 32'(PIX_FULL),
                  COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        push_pixel(PIX_HALF - 1'b1, PIX_HALF, PIX_FULL);
        push_pixel('0, '0, 16'h1234);
        drain();

        // Fixed amount of three.
        configure(32'h0003_0000, 32'h0003_0000, $urandom, $urandom,
                  '0, '0, '0, 32'h0003_0000);
        repeat (3) push_pixel(pick_pixel(), pick_pixel(), pick_level());
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_setup();
            sender_quiet = ($urandom_range(0, 3) == 0);
            receiver_quiet = ($urandom_range(0, 3) == 0);
            if (phase == PRESSURE_PHASE) begin
                sender_quiet = 1'b1;
                receiver_quiet = 1'b1;
            end
            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                if (phase == PRESSURE_PHASE && n % 80 == 0)
                    hold_request = HOLD_OFF_CYCLES;
                push_pixel(pick_pixel(), pick_pixel(), pick_level());
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/aum_pkg.sv
src/aum_cfg.sv
src/aum_amount.sv
src/aum_blend.sv
src/adaptive_unsharp_mask_blend.sv
sim/aum_blend_checker.sv
sim/tb.sv
